[rtl/core/lrme_pkg.sv]
package lrme_pkg;

    // Default build values
    localparam int DEF_CHAIN_LENGTH = 64;
    localparam int DEF_DIMENSIONS   = 3;

    // Field widths
    localparam int COORD_W    = 10;
    localparam int IDX_W      = 6;
    localparam int CHOICE_W   = 3;
    localparam int ENERGY_W   = 8;
    localparam int DU_W       = 12;
    localparam int MOVE_W     = 2;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int WORD_W     = 3 * COORD_W;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 2'd0,
        OP_SET_HEAD = 2'd1,
        OP_PROPOSE  = 2'd2,
        OP_ACCEPT   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_HEAD,
        ST_P_HM,
        ST_P_TL,
        ST_P_TM,
        ST_P_SCAN0,
        ST_SCAN,
        ST_CALC,
        ST_MUL,
        ST_A_HEAD,
        ST_A_WR,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_FIN
    } state_t;

    // What the coordinate memory is read for in a cycle
    typedef enum logic [2:0] {
        RD_NONE,
        RD_HEAD,
        RD_HM,
        RD_TL,
        RD_TM,
        RD_SCAN,
        RD_SWEEP
    } rd_sel_t;

    typedef struct packed {
        logic    start;
        rd_sel_t rd_sel;
        logic    scan_init;
        logic    calc_dirs;
        logic    calc_delta;
        logic    calc_du;
        logic    accept_wr;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic blocked;
        logic scan_end;
        logic shifted;
        logic sweep_last;
    } dp_status_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [MOVE_W-1:0]  move_t;

endpackage

[rtl/core/lrme_ram.sv]
module lrme_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/lrme_ctrl.sv]
module lrme_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  lrme_pkg::op_t        in_op,
    input  logic                 m_tready,
    input  lrme_pkg::dp_status_t status,
    output lrme_pkg::dp_cmd_t    cmd,
    output logic                 s_tready,
    output logic                 m_tvalid
);
    import lrme_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_PROPOSE: state_next = ST_P_HEAD;
                        OP_ACCEPT:  state_next = ST_A_HEAD;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end
            ST_P_HEAD:  state_next = ST_P_HM;
            ST_P_HM:    state_next = ST_P_TL;
            ST_P_TL:    state_next = ST_P_TM;
            ST_P_TM:    state_next = ST_P_SCAN0;
            ST_P_SCAN0: state_next = ST_SCAN;
            ST_SCAN: begin
                priority if (status.blocked) begin
                    state_next = ST_FIN;
                end else if (status.scan_end) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:    state_next = ST_MUL;
            ST_MUL:     state_next = ST_FIN;
            ST_A_HEAD:  state_next = ST_A_WR;
            ST_A_WR:    state_next = status.shifted ? ST_SWEEP : ST_FIN;
            ST_SWEEP: begin
                if (status.sweep_last) begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END: state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        cmd = '0;
        cmd.rd_sel = RD_NONE;
        unique case (state_reg)
            ST_IDLE:    cmd.start = s_tvalid;
            ST_P_HEAD:  cmd.rd_sel = RD_HEAD;
            ST_P_HM:    cmd.rd_sel = RD_HM;
            ST_P_TL:    cmd.rd_sel = RD_TL;
            ST_P_TM: begin
                cmd.rd_sel    = RD_TM;
                cmd.calc_dirs = 1'b1;
            end
            ST_P_SCAN0: begin
                cmd.rd_sel    = RD_SCAN;
                cmd.scan_init = 1'b1;
            end
            ST_SCAN: begin
                if (!status.blocked && !status.scan_end) begin
                    cmd.rd_sel = RD_SCAN;
                end
            end
            ST_CALC:    cmd.calc_delta = 1'b1;
            ST_MUL:     cmd.calc_du = 1'b1;
            ST_A_HEAD:  cmd.rd_sel = RD_HEAD;
            ST_A_WR:    cmd.accept_wr = 1'b1;
            ST_SWEEP:   cmd.rd_sel = RD_SWEEP;
            ST_FIN:     cmd.load_out = out_free;
            default:    cmd = '0;
        endcase
    end

    // Output valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[rtl/core/lrme_datapath.sv]
module lrme_datapath #(
    parameter int CHAIN_LENGTH = lrme_pkg::DEF_CHAIN_LENGTH,
    parameter int DIMENSIONS   = lrme_pkg::DEF_DIMENSIONS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [lrme_pkg::IN_DATA_W-1:0]        in_data,
    input  lrme_pkg::op_t                         in_op,
    input  logic                                  cfg_we,
    input  logic [lrme_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lrme_pkg::ENERGY_W-1:0]         cfg_data,
    input  lrme_pkg::dp_cmd_t                     cmd,
    output lrme_pkg::dp_status_t                  status,
    output logic [lrme_pkg::OUT_DATA_W-1:0]       out_data,
    output logic                                  ram_we,
    output logic [$clog2(CHAIN_LENGTH)-1:0]       ram_waddr,
    output logic [lrme_pkg::WORD_W-1:0]           ram_wdata,
    output logic [$clog2(CHAIN_LENGTH)-1:0]       ram_raddr,
    input  logic [lrme_pkg::WORD_W-1:0]           ram_rdata
);
    import lrme_pkg::*;

    localparam int AW      = $clog2(CHAIN_LENGTH);
    localparam int DIST_W  = COORD_W + 3;
    localparam int SCAN_W  = $clog2(CHAIN_LENGTH + 3 * (1 << COORD_W)) + 1;
    localparam int CNT_W   = $clog2(CHAIN_LENGTH + 1);
    localparam int DELTA_W = CNT_W + 2;
    localparam int PROD_W  = DELTA_W + ENERGY_W;
    localparam int NDIR    = 2 * DIMENSIONS - 1;
    localparam int TWO_N   = 2 * CHAIN_LENGTH;

    function automatic logic [AW-1:0] ring_step(input logic [AW-1:0] s, input logic bwd);
        logic [AW-1:0] r;
        if (bwd) begin
            r = (s == '0) ? AW'(CHAIN_LENGTH - 1) : s - 1'b1;
        end else begin
            r = (s == AW'(CHAIN_LENGTH - 1)) ? '0 : s + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [COORD_W:0] absdiff(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] t;
        t = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (t < 0) begin
            t = -t;
        end
        return t;
    endfunction

    // Input fields
    logic [IDX_W-1:0]    in_idx;
    coord_t              in_c [3];
    logic                in_back;
    logic [CHOICE_W-1:0] in_choice;

    assign in_idx    = in_data[5:0];
    assign in_c[0]   = in_data[15:6];
    assign in_c[1]   = in_data[25:16];
    assign in_c[2]   = in_data[35:26];
    assign in_back   = in_data[36];
    assign in_choice = in_data[39:37];

    // State
    logic signed [ENERGY_W-1:0] energy_reg;
    logic                       skip_reg;
    logic [AW-1:0]              head_reg;
    logic                       back_reg;
    move_t                      pend_reg [3];
    rd_sel_t                    rsel_reg;

    op_t                        op_reg;
    logic [CHOICE_W-1:0]        choice_reg;
    coord_t                     hc_reg [3];
    coord_t                     hmc_reg [3];
    coord_t                     tlc_reg [3];
    coord_t                     tmc_reg [3];
    coord_t                     tgt_reg [3];
    coord_t                     org_reg [3];
    logic [SCAN_W-1:0]          scan_idx_reg;
    logic [CNT_W-1:0]           cnt_nh_reg, cnt_nt_reg, cnt_h_reg, cnt_t_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [DU_W-1:0]            du_reg;
    logic                       free_reg;
    logic                       shift_reg;
    logic [AW-1:0]              sweep_idx_reg;
    logic [AW-1:0]              sweep_wr_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;

    // Ring neighbors of the head
    logic [AW-1:0] hm_slot, tl_slot, tm_slot;
    assign hm_slot = ring_step(head_reg, !back_reg);
    assign tl_slot = ring_step(head_reg, back_reg);
    assign tm_slot = ring_step(tl_slot, back_reg);

    // Memory word unpack
    coord_t rd_c [3];
    assign rd_c[0] = ram_rdata[COORD_W-1:0];
    assign rd_c[1] = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_c[2] = ram_rdata[3*COORD_W-1:2*COORD_W];

    // Set head slot reduced modulo the chain length
    logic [31:0] head_mod;
    always_comb begin
        head_mod = 32'(in_idx);
        for (int k = 4; k >= 0; k--) begin
            if (head_mod >= (32'(CHAIN_LENGTH) << k)) begin
                head_mod = head_mod - (32'(CHAIN_LENGTH) << k);
            end
        end
    end

    // Move selection: straight ahead from the head bond, or a turn
    logic signed [COORD_W:0] bond_diff [3];
    move_t                   sgn [3];
    move_t                   mv [3];
    coord_t                  tgt_c [3];
    logic [1:0]              axis;
    logic [1:0]              other;
    logic [CHOICE_W-1:0]     ch;

    always_comb begin
        axis = 2'd0;
        for (int d = 0; d < 3; d++) begin
            bond_diff[d] = {hc_reg[d][COORD_W-1], hc_reg[d]} -
                           {hmc_reg[d][COORD_W-1], hmc_reg[d]};
            sgn[d] = 2'sb00;
            if (d < DIMENSIONS) begin
                if (bond_diff[d] > 0) begin
                    sgn[d] = 2'sb01;
                end else if (bond_diff[d] < 0) begin
                    sgn[d] = 2'sb11;
                end
                if (bond_diff[d] != 0) begin
                    axis = 2'(d);
                end
            end
        end
        ch = (32'(choice_reg) >= NDIR) ? '0 : choice_reg;
        if (ch >= CHOICE_W'(3)) begin
            other = (axis == 2'd2) ? 2'd1 : 2'd2;
        end else begin
            other = (axis == 2'd0) ? 2'd1 : 2'd0;
        end
        for (int d = 0; d < 3; d++) begin
            if (ch == '0) begin
                mv[d] = sgn[d];
            end else if (other == 2'(d)) begin
                mv[d] = ch[0] ? 2'sb01 : 2'sb11;
            end else begin
                mv[d] = 2'sb00;
            end
            tgt_c[d] = hc_reg[d] + {{(COORD_W-MOVE_W){mv[d][1]}}, mv[d]};
        end
    end

    // Scan evaluation of the monomer returned by the memory
    logic [DIST_W-1:0] dh, dt, dnh, dnt, dmin;
    logic              scan_valid, skip_cond;
    logic [SCAN_W-1:0] scan_next;

    always_comb begin
        dh  = '0;
        dt  = '0;
        dnh = '0;
        dnt = '0;
        for (int d = 0; d < 3; d++) begin
            if (d < DIMENSIONS) begin
                dh  = dh  + DIST_W'(absdiff(rd_c[d], hc_reg[d]));
                dt  = dt  + DIST_W'(absdiff(rd_c[d], tlc_reg[d]));
                dnh = dnh + DIST_W'(absdiff(rd_c[d], tgt_reg[d]));
                dnt = dnt + DIST_W'(absdiff(rd_c[d], tmc_reg[d]));
            end
        end
        scan_valid = (rsel_reg == RD_SCAN);
        skip_cond  = skip_reg && (dh > DIST_W'(3)) && (dt > DIST_W'(3));
        dmin       = (dh < dt) ? dh : dt;
        if (cmd.scan_init) begin
            scan_next = '0;
        end else if (skip_cond) begin
            scan_next = scan_idx_reg + SCAN_W'(dmin) - SCAN_W'(2);
        end else begin
            scan_next = scan_idx_reg + 1'b1;
        end
    end

    // Energy product with saturation
    logic signed [PROD_W-1:0] prod;
    logic [DU_W-1:0]          du_sat;
    always_comb begin
        prod = PROD_W'(delta_reg) * PROD_W'(energy_reg);
        if (prod > PROD_W'(2047)) begin
            du_sat = 12'h7FF;
        end else if (prod < -PROD_W'(2048)) begin
            du_sat = 12'h800;
        end else begin
            du_sat = prod[DU_W-1:0];
        end
    end

    // Accepted move: tail goes to head plus move, recenter check
    coord_t acc_new [3];
    coord_t sweep_c [3];
    logic   shift_det;
    always_comb begin
        shift_det = 1'b0;
        for (int d = 0; d < 3; d++) begin
            acc_new[d] = rd_c[d] + {{(COORD_W-MOVE_W){pend_reg[d][1]}}, pend_reg[d]};
            sweep_c[d] = (d < DIMENSIONS) ? rd_c[d] - org_reg[d] : rd_c[d];
            if (d < DIMENSIONS && (32'(absdiff(acc_new[d], '0)) > TWO_N)) begin
                shift_det = 1'b1;
            end
        end
    end

    assign status.blocked    = scan_valid && (dnh == '0);
    assign status.scan_end   = scan_valid && (scan_next >= SCAN_W'(CHAIN_LENGTH));
    assign status.shifted    = shift_det;
    assign status.sweep_last = (sweep_idx_reg == AW'(CHAIN_LENGTH - 1));

    // Memory read address
    always_comb begin
        unique case (cmd.rd_sel)
            RD_HEAD:  ram_raddr = head_reg;
            RD_HM:    ram_raddr = hm_slot;
            RD_TL:    ram_raddr = tl_slot;
            RD_TM:    ram_raddr = tm_slot;
            RD_SCAN:  ram_raddr = scan_next[AW-1:0];
            RD_SWEEP: ram_raddr = sweep_idx_reg;
            default:  ram_raddr = '0;
        endcase
    end

    // Memory write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        priority if (cmd.accept_wr) begin
            ram_we    = 1'b1;
            ram_waddr = tl_slot;
            ram_wdata = {acc_new[2], acc_new[1], acc_new[0]};
        end else if (rsel_reg == RD_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_wr_reg;
            ram_wdata = {sweep_c[2], sweep_c[1], sweep_c[0]};
        end else if (cmd.start && in_op == OP_WRITE && 32'(in_idx) < CHAIN_LENGTH) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(in_idx);
            ram_wdata = {(DIMENSIONS > 2) ? in_c[2] : coord_t'(0), in_c[1], in_c[0]};
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= -8'sd1;
            skip_reg   <= 1'b0;
            head_reg   <= '0;
            back_reg   <= 1'b0;
            rsel_reg   <= RD_NONE;
            for (int d = 0; d < 3; d++) begin
                pend_reg[d] <= 2'sb00;
            end
        end else begin
            rsel_reg <= cmd.rd_sel;
            if (cfg_we) begin
                if (cfg_index == CFG_ENERGY) begin
                    energy_reg <= cfg_data;
                end else if (cfg_index == CFG_SKIP) begin
                    skip_reg <= cfg_data[0];
                end
            end
            if (cmd.start && in_op == OP_SET_HEAD) begin
                head_reg <= head_mod[AW-1:0];
                back_reg <= in_back;
            end
            if (cmd.calc_dirs) begin
                pend_reg <= mv;
            end
            if (cmd.accept_wr) begin
                head_reg <= tl_slot;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg     <= in_op;
            choice_reg <= in_choice;
            free_reg   <= 1'b0;
            du_reg     <= '0;
            shift_reg  <= 1'b0;
        end
        unique case (rsel_reg)
            RD_HEAD: hc_reg  <= rd_c;
            RD_HM:   hmc_reg <= rd_c;
            RD_TL:   tlc_reg <= rd_c;
            RD_TM:   tmc_reg <= rd_c;
            default: ;
        endcase
        if (cmd.calc_dirs) begin
            tgt_reg <= tgt_c;
        end
        if (cmd.rd_sel == RD_SCAN) begin
            scan_idx_reg <= scan_next;
        end
        if (cmd.scan_init) begin
            cnt_nh_reg <= '0;
            cnt_nt_reg <= '0;
            cnt_h_reg  <= '0;
            cnt_t_reg  <= '0;
        end else if (scan_valid) begin
            cnt_nh_reg <= cnt_nh_reg + CNT_W'(dnh == DIST_W'(1));
            cnt_nt_reg <= cnt_nt_reg + CNT_W'(dnt == DIST_W'(1));
            cnt_h_reg  <= cnt_h_reg  + CNT_W'(dh  == DIST_W'(1));
            cnt_t_reg  <= cnt_t_reg  + CNT_W'(dt  == DIST_W'(1));
        end
        if (cmd.calc_delta) begin
            delta_reg <= DELTA_W'(cnt_nh_reg) + DELTA_W'(cnt_nt_reg)
                       - DELTA_W'(cnt_h_reg) - DELTA_W'(cnt_t_reg);
        end
        if (cmd.calc_du) begin
            du_reg   <= du_sat;
            free_reg <= 1'b1;
        end
        if (cmd.accept_wr) begin
            org_reg       <= acc_new;
            shift_reg     <= shift_det;
            sweep_idx_reg <= '0;
        end
        if (cmd.rd_sel == RD_SWEEP) begin
            sweep_idx_reg <= sweep_idx_reg + 1'b1;
            sweep_wr_reg  <= sweep_idx_reg;
        end
        if (cmd.load_out) begin
            unique case (op_reg)
                OP_PROPOSE: out_data_reg <= {4'b0, 1'b0, pend_reg[2], pend_reg[1],
                                             pend_reg[0], du_reg, free_reg};
                OP_ACCEPT:  out_data_reg <= {4'b0, shift_reg, pend_reg[2], pend_reg[1],
                                             pend_reg[0], 12'b0, 1'b0};
                default:    out_data_reg <= '0;
            endcase
        end
    end

    assign out_data = out_data_reg;
endmodule

[rtl/core/lattice_reptation_move_engine_top.sv]
// Channel | Direction | Ports                    | Payload
// s_      | in        | s_tvalid/s_tready        | tuser opcode, tdata index, coords, walk, choice
// m_      | out       | m_tvalid/m_tready        | tdata site_free, du, move, chain_shifted
// cfg_    | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data (always ready)
//
// A proposal scans the chain, one memory read per monomer visited (CHAIN_LENGTH of them
// when skipping is off); a proposal whose target is occupied ends the scan there.
// An accept that recenters the chain adds a read and write sweep over the coordinate
// memory. Synchronous active-low reset, no clearing pass.
// A new transaction is taken while the previous result waits in the output register;
// a stalled output holds the block in its final cycle until the result register frees.
module lattice_reptation_move_engine_top #(
    parameter int CHAIN_LENGTH = lrme_pkg::DEF_CHAIN_LENGTH,
    parameter int DIMENSIONS   = lrme_pkg::DEF_DIMENSIONS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] monomer_index, [15:6] coord_x, [25:16] coord_y, [35:26] coord_z,
    // [36] walk_backward, [39:37] choice_index
    input  logic [lrme_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] opcode
    input  logic [lrme_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] site_free, [12:1] energy_change, [14:13] move_dx, [16:15] move_dy,
    // [18:17] move_dz, [19] chain_shifted, [23:20] zero
    output logic [lrme_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrme_pkg::ENERGY_W-1:0]     cfg_data
);
    import lrme_pkg::*;

    localparam int AW = $clog2(CHAIN_LENGTH);

    dp_cmd_t            cmd;
    dp_status_t         status;
    op_t                in_op;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    assign in_op     = op_t'(s_tuser);
    assign cfg_ready = 1'b1;

    lrme_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (in_op),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    lrme_datapath #(
        .CHAIN_LENGTH (CHAIN_LENGTH),
        .DIMENSIONS   (DIMENSIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .in_op     (in_op),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lrme_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHAIN_LENGTH)
    ) u_coords (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

[rtl/core/lrme_checker.sv]
module lrme_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lrme_pkg::OUT_DATA_W-1:0]   m_tdata
);
    // One input transaction at a time: busy right after an accept
    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Energy is reported only for a free site
    a_du_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[12:1] == 12'h000)
        else $error("energy without free site");

    // Recenter flag and free flag never together
    a_shift_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> !m_tdata[0])
        else $error("shifted result flagged as proposal");

    // Move components are unit steps
    a_move_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[14:13] != 2'b10 && m_tdata[16:15] != 2'b10 &&
                     m_tdata[18:17] != 2'b10)
        else $error("move component out of range");
endmodule

bind lattice_reptation_move_engine_top lrme_checker u_lrme_checker (.*);

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import lrme_pkg::*;

    localparam int NSLOT      = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 3000;

    typedef struct {
        bit        site_free;
        bit [11:0] energy_change;
        bit [1:0]  move_dx;
        bit [1:0]  move_dy;
        bit [1:0]  move_dz;
        bit        chain_shifted;
    } move_result_t;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ENERGY_W-1:0]   cfg_data = '0;

    lattice_reptation_move_engine_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the block state
    int  chain_xyz [NSLOT][3];
    int  head_slot;
    bit  walk_back;
    int  pend_move [3];
    int  contact_e = -1;
    bit  skip_on = 0;

    move_result_t result_q[$];
    int  fail_count = 0;
    bit  last_free;
    int  burst_left = 0;
    bit  long_hold_req = 0;

    function automatic int sext10(bit [9:0] v);
        logic signed [9:0] t;
        t = v;
        return t;
    endfunction

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int ring_next(int s, bit backward);
        return backward ? (s + NSLOT - 1) % NSLOT : (s + 1) % NSLOT;
    endfunction

    // Proposal: pick the unit move, scan the chain, count contacts
    function automatic bit propose_move(int choice, output int du);
        int dirs [5][3];
        int tgt [3];
        int hm, tl, tm, axis, cnt, diff, dh, dt, dnh, dnt, p;
        int nn_h, nn_t, nn_nh, nn_nt;
        hm = ring_next(head_slot, !walk_back);
        tl = ring_next(head_slot, walk_back);
        tm = ring_next(tl, walk_back);
        axis = 0; cnt = 1; du = 0;
        nn_h = 0; nn_t = 0; nn_nh = 0; nn_nt = 0;
        foreach (dirs[a, b]) dirs[a][b] = 0;
        for (int d = 0; d < 3; d++) begin
            diff = chain_xyz[head_slot][d] - chain_xyz[hm][d];
            dirs[0][d] = diff > 0 ? 1 : (diff < 0 ? -1 : 0);
            if (diff != 0) axis = d;
        end
        for (int d = 0; d < 3; d++) begin
            if (d != axis) begin
                dirs[cnt][d] = 1;
                dirs[cnt + 1][d] = -1;
                cnt += 2;
            end
        end
        if (choice >= 5) choice = 0;
        for (int d = 0; d < 3; d++) begin
            pend_move[d] = dirs[choice][d];
            tgt[d] = sext10(10'(chain_xyz[head_slot][d] + pend_move[d]));
        end
        for (int i = 0; i < NSLOT; i++) begin
            dh = 0; dt = 0; dnh = 0; dnt = 0;
            for (int d = 0; d < 3; d++) begin
                p = chain_xyz[i][d];
                dh += iabs(p - chain_xyz[head_slot][d]);
                dt += iabs(p - chain_xyz[tl][d]);
                dnh += iabs(p - tgt[d]);
                dnt += iabs(p - chain_xyz[tm][d]);
            end
            if (dnh == 0) return 0;
            if (dnh == 1) nn_nh++;
            if (dnt == 1) nn_nt++;
            if (dh == 1) nn_h++;
            if (dt == 1) nn_t++;
            if (skip_on && dh > 3 && dt > 3) i += (dh < dt ? dh : dt) - 3;
        end
        du = contact_e * (nn_nh + nn_nt - nn_h - nn_t);
        if (du > 2047) du = 2047;
        if (du < -2048) du = -2048;
        return 1;
    endfunction

    // Accept: tail takes the target site, recenter if the head strays
    function automatic bit accept_move();
        int hp;
        int org [3];
        bit sh;
        hp = ring_next(head_slot, walk_back);
        sh = 0;
        for (int d = 0; d < 3; d++)
            chain_xyz[hp][d] = sext10(10'(chain_xyz[head_slot][d] + pend_move[d]));
        head_slot = hp;
        for (int d = 0; d < 3; d++) if (iabs(chain_xyz[hp][d]) > 2 * NSLOT) sh = 1;
        if (sh) begin
            for (int d = 0; d < 3; d++) org[d] = chain_xyz[hp][d];
            for (int i = 0; i < NSLOT; i++)
                for (int d = 0; d < 3; d++)
                    chain_xyz[i][d] = sext10(10'(chain_xyz[i][d] - org[d]));
        end
        return sh;
    endfunction

    // Work out the result of one accepted input transaction
    function automatic move_result_t predict_result(op_t op, logic [IN_DATA_W-1:0] data);
        move_result_t r;
        int du;
        int idx;
        r = '{default: 0};
        idx = data[5:0];
        du = 0;
        case (op)
            OP_WRITE: begin
                chain_xyz[idx][0] = sext10(data[15:6]);
                chain_xyz[idx][1] = sext10(data[25:16]);
                chain_xyz[idx][2] = sext10(data[35:26]);
            end
            OP_SET_HEAD: begin
                head_slot = idx % NSLOT;
                walk_back = data[36];
            end
            OP_PROPOSE: begin
                r.site_free = propose_move(data[39:37], du);
                r.energy_change = du[11:0];
                last_free = r.site_free;
            end
            default: r.chain_shifted = accept_move();
        endcase
        if (op == OP_PROPOSE || op == OP_ACCEPT) begin
            r.move_dx = pend_move[0][1:0];
            r.move_dy = pend_move[1][1:0];
            r.move_dz = pend_move[2][1:0];
        end
        return r;
    endfunction

    // Send one input transaction, sender idles in bursts
    task automatic send_raw(op_t op, logic [IN_DATA_W-1:0] data);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid = 0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid = 1;
        s_tuser = op;
        s_tdata = data;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        result_q.push_back(predict_result(op, data));
    endtask

    task automatic send_item(op_t op, int idx, int x, int y, int z, bit back, int choice);
        logic [IN_DATA_W-1:0] data;
        data = {choice[2:0], back, z[9:0], y[9:0], x[9:0], idx[5:0]};
        send_raw(op, data);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        wait (result_q.size() == 0);
        repeat (NSLOT + 10) @(negedge aclk);
    endtask

    // Register write, only while nothing is in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        drain();
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = value[7:0];
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        if (idx == CFG_ENERGY) contact_e = sext10({{2{value[7]}}, value[7:0]});
        else if (idx == CFG_SKIP) skip_on = value[0];
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // Load every slot along a random lattice walk
    task automatic load_walk(int bx, int by, int bz);
        int p [3];
        int ax;
        p[0] = bx; p[1] = by; p[2] = bz;
        for (int s = 0; s < NSLOT; s++) begin
            send_item(OP_WRITE, s, p[0], p[1], p[2], 0, 0);
            ax = $urandom_range(0, 2);
            p[ax] += $urandom_range(0, 1) ? 1 : -1;
        end
    endtask

    task automatic test_directed();
        load_walk(0, 0, 0);
        send_item(OP_SET_HEAD, 0, 0, 0, 0, 0, 0);
        // accept with the reset move, then every choice incl. out of range
        send_item(OP_ACCEPT, 0, 0, 0, 0, 0, 0);
        for (int c = 0; c < 8; c++) send_item(OP_PROPOSE, 0, 0, 0, 0, 0, c);
        // packed chain: many contacts drive du into saturation
        for (int s = 0; s < NSLOT; s++) send_item(OP_WRITE, s, 2, 0, 0, 0, 0);
        send_item(OP_WRITE, 0, 0, 0, 0, 0, 0);
        send_item(OP_WRITE, 63, -1, 0, 0, 0, 0);
        send_item(OP_SET_HEAD, 0, 0, 0, 0, 0, 0);
        write_reg(CFG_ENERGY, 127);
        send_item(OP_PROPOSE, 0, 0, 0, 0, 0, 0);
        write_reg(CFG_ENERGY, -128);
        send_item(OP_PROPOSE, 0, 0, 0, 0, 0, 0);
        // tail sits on the target site
        send_item(OP_WRITE, 1, 1, 0, 0, 0, 0);
        send_item(OP_PROPOSE, 0, 0, 0, 0, 0, 0);
        // non-unit bond, then a zero bond
        send_item(OP_WRITE, 63, -5, 3, 0, 0, 0);
        send_item(OP_PROPOSE, 0, 0, 0, 0, 0, 0);
        send_item(OP_WRITE, 63, 0, 0, 0, 0, 0);
        send_item(OP_PROPOSE, 0, 0, 0, 0, 0, 3);
        // wrap at the coordinate extremes, accept recenters
        send_item(OP_WRITE, 5, 511, 511, 511, 0, 0);
        send_item(OP_WRITE, 4, 510, 511, 511, 0, 0);
        send_item(OP_WRITE, 6, -512, -512, -512, 0, 0);
        send_item(OP_SET_HEAD, 5, 0, 0, 0, 1, 0);
        send_item(OP_PROPOSE, 63, 0, 0, 0, 1, 0);
        send_item(OP_ACCEPT, 0, 0, 0, 0, 0, 0);
        write_reg(CFG_SKIP, 1);
        load_walk(0, 0, 0);
        send_item(OP_SET_HEAD, 63, 0, 0, 0, 1, 0);
        send_item(OP_PROPOSE, 0, 0, 0, 0, 0, 1);
        send_item(OP_ACCEPT, 0, 0, 0, 0, 0, 0);
    endtask

    // Mostly propose/accept runs on a loaded walk, some noise
    task automatic test_random_phase(int energy, bit skip, int base, int n_ops);
        int r;
        write_reg(CFG_ENERGY, energy);
        write_reg(CFG_SKIP, skip);
        load_walk(base + $urandom_range(0, 6), base, -base);
        send_item(OP_SET_HEAD, $urandom_range(0, 63), 0, 0, 0, $urandom_range(0, 1), 0);
        for (int k = 0; k < n_ops; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_item(OP_PROPOSE, $urandom_range(0, 63), 0, 0, 0, 0,
                          $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                    : $urandom_range(0, 4));
                if (last_free && $urandom_range(0, 3) != 0)
                    send_item(OP_ACCEPT, 0, 0, 0, 0, 0, 0);
            end else if (r < 70) begin
                send_item(OP_ACCEPT, 0, 0, 0, 0, 0, 0);
            end else if (r < 80) begin
                send_item(OP_SET_HEAD, $urandom_range(0, 63), 0, 0, 0,
                          $urandom_range(0, 1), 0);
            end else begin
                send_raw(op_t'($urandom_range(0, 3)), IN_DATA_W'({$urandom, $urandom}));
            end
        end
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        long_hold_req = 1;
        for (int k = 0; k < 12; k++)
            send_item(OP_PROPOSE, 0, 0, 0, 0, 0, $urandom_range(0, 4));
    endtask

    // Receiver stall pattern
    initial begin
        int hold, mode, mode_left;
        hold = 0; mode = 0; mode_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready = 0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: m_tready = 1;
                    1: m_tready = $urandom_range(0, 1);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin
        move_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $error("result with no expectation: %h", m_tdata);
                fail_count++;
            end else begin
                e = result_q.pop_front();
                if (m_tdata[0] !== e.site_free) begin
                    $error("site_free exp %0d got %0d", e.site_free, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[12:1] !== e.energy_change) begin
                    $error("energy_change exp %h got %h", e.energy_change, m_tdata[12:1]);
                    fail_count++;
                end
                if (m_tdata[14:13] !== e.move_dx) begin
                    $error("move_dx exp %h got %h", e.move_dx, m_tdata[14:13]);
                    fail_count++;
                end
                if (m_tdata[16:15] !== e.move_dy) begin
                    $error("move_dy exp %h got %h", e.move_dy, m_tdata[16:15]);
                    fail_count++;
                end
                if (m_tdata[18:17] !== e.move_dz) begin
                    $error("move_dz exp %h got %h", e.move_dz, m_tdata[18:17]);
                    fail_count++;
                end
                if (m_tdata[19] !== e.chain_shifted) begin
                    $error("chain_shifted exp %0d got %0d", e.chain_shifted, m_tdata[19]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        test_directed();
        test_backpressure();
        test_random_phase(-1, 0, 0, 120);
        test_random_phase(127, 1, 0, 120);
        test_random_phase(-128, 0, 125, 120);
        test_random_phase($urandom_range(0, 255), 1, 505, 120);
        test_random_phase(0, 0, 3, 80);
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[lattice_reptation_move_engine_top.f]
rtl/core/lrme_pkg.sv
rtl/core/lrme_ram.sv
rtl/core/lrme_ctrl.sv
rtl/core/lrme_datapath.sv
rtl/core/lattice_reptation_move_engine_top.sv
rtl/core/lrme_checker.sv
test/tb.sv
